@@ src/small_sorting_network_assert.svh @@
// assertion macros for the small sorting network
`ifndef SMALL_SORTING_NETWORK_ASSERT_SVH
`define SMALL_SORTING_NETWORK_ASSERT_SVH
// property that must hold at every rising clock edge outside reset
`define SSN_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`endif

@@ src/ssn_pkg.sv @@
// package with types, network table and float compare for the sorting network
package ssn_pkg;

	localparam int NetSize = 18;
	localparam int NetSteps = 82;
	localparam int StepW = 7;
	localparam int IdxW = 5;
	localparam logic [31:0] PosInf = 32'h7F80_0000;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_EMIT
	} ssn_state_t;

	typedef struct packed {
		logic store;
		logic start;
		logic sort_step;
		logic emit_step;
	} ssn_cmd_t;

	typedef struct packed {
		logic set_full;
		logic sort_done;
		logic emit_last;
	} ssn_status_t;

	function automatic logic [9:0] net_pair(input logic [StepW-1:0] k);
		logic [9:0] r;
		case (k)
			7'd0: r = {5'd0, 5'd16};   7'd1: r = {5'd1, 5'd17};
			7'd2: r = {5'd2, 5'd10};   7'd3: r = {5'd3, 5'd11};
			7'd4: r = {5'd4, 5'd12};   7'd5: r = {5'd5, 5'd13};
			7'd6: r = {5'd6, 5'd14};   7'd7: r = {5'd7, 5'd15};
			7'd8: r = {5'd0, 5'd8};    7'd9: r = {5'd1, 5'd9};
			7'd10: r = {5'd2, 5'd6};   7'd11: r = {5'd3, 5'd7};
			7'd12: r = {5'd10, 5'd14}; 7'd13: r = {5'd11, 5'd15};
			7'd14: r = {5'd8, 5'd16};  7'd15: r = {5'd9, 5'd17};
			7'd16: r = {5'd0, 5'd4};   7'd17: r = {5'd1, 5'd5};
			7'd18: r = {5'd6, 5'd10};  7'd19: r = {5'd7, 5'd11};
			7'd20: r = {5'd8, 5'd12};  7'd21: r = {5'd9, 5'd13};
			7'd22: r = {5'd4, 5'd16};  7'd23: r = {5'd5, 5'd17};
			7'd24: r = {5'd0, 5'd2};   7'd25: r = {5'd1, 5'd3};
			7'd26: r = {5'd4, 5'd8};   7'd27: r = {5'd5, 5'd9};
			7'd28: r = {5'd12, 5'd16}; 7'd29: r = {5'd13, 5'd17};
			7'd30: r = {5'd0, 5'd1};   7'd31: r = {5'd4, 5'd6};
			7'd32: r = {5'd5, 5'd7};   7'd33: r = {5'd8, 5'd10};
			7'd34: r = {5'd9, 5'd11};  7'd35: r = {5'd12, 5'd14};
			7'd36: r = {5'd13, 5'd15}; 7'd37: r = {5'd2, 5'd16};
			7'd38: r = {5'd3, 5'd17};  7'd39: r = {5'd2, 5'd8};
			7'd40: r = {5'd3, 5'd9};   7'd41: r = {5'd6, 5'd12};
			7'd42: r = {5'd7, 5'd13};  7'd43: r = {5'd10, 5'd16};
			7'd44: r = {5'd11, 5'd17}; 7'd45: r = {5'd2, 5'd4};
			7'd46: r = {5'd3, 5'd5};   7'd47: r = {5'd6, 5'd8};
			7'd48: r = {5'd7, 5'd9};   7'd49: r = {5'd10, 5'd12};
			7'd50: r = {5'd11, 5'd13}; 7'd51: r = {5'd14, 5'd16};
			7'd52: r = {5'd15, 5'd17}; 7'd53: r = {5'd2, 5'd3};
			7'd54: r = {5'd4, 5'd5};   7'd55: r = {5'd6, 5'd7};
			7'd56: r = {5'd8, 5'd9};   7'd57: r = {5'd10, 5'd11};
			7'd58: r = {5'd12, 5'd13}; 7'd59: r = {5'd14, 5'd15};
			7'd60: r = {5'd16, 5'd17}; 7'd61: r = {5'd1, 5'd16};
			7'd62: r = {5'd3, 5'd10};  7'd63: r = {5'd5, 5'd12};
			7'd64: r = {5'd7, 5'd14};  7'd65: r = {5'd1, 5'd8};
			7'd66: r = {5'd9, 5'd16};  7'd67: r = {5'd3, 5'd6};
			7'd68: r = {5'd7, 5'd10};  7'd69: r = {5'd11, 5'd14};
			7'd70: r = {5'd1, 5'd4};   7'd71: r = {5'd5, 5'd8};
			7'd72: r = {5'd9, 5'd12};  7'd73: r = {5'd13, 5'd16};
			7'd74: r = {5'd1, 5'd2};   7'd75: r = {5'd3, 5'd4};
			7'd76: r = {5'd5, 5'd6};   7'd77: r = {5'd7, 5'd8};
			7'd78: r = {5'd9, 5'd10};  7'd79: r = {5'd11, 5'd12};
			7'd80: r = {5'd13, 5'd14}; 7'd81: r = {5'd15, 5'd16};
			default: r = {5'd0, 5'd1};
		endcase
		return r;
	endfunction

	function automatic logic [31:0] order_key(input logic [31:0] x);
		logic [31:0] y;
		y = (x[30:0] == 31'd0) ? 32'd0 : x;
		return y[31] ? ~y : (y | 32'h8000_0000);
	endfunction

	function automatic logic float_greater(input logic [31:0] a, input logic [31:0] b);
		logic nan_a;
		logic nan_b;
		nan_a = a[30:0] > 31'h7F80_0000;
		nan_b = b[30:0] > 31'h7F80_0000;
		return !nan_a && !nan_b && (order_key(a) > order_key(b));
	endfunction

endpackage

@@ src/ssn_stream_if.sv @@
// valid/ready stream interface
interface ssn_stream_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	logic last;
	modport source(output valid, output data, output last, input ready);
	modport sink(input valid, input data, input last, output ready);
endinterface

@@ src/ssn_datapath.sv @@
// element store, one compare-exchange unit and a combinational read of the store for output
module ssn_datapath #(
	parameter int MAX_ELEMENTS = 18
) (
	input logic clk,
	input logic arst_n,
	input ssn_pkg::ssn_cmd_t cmd,
	input logic [31:0] in_value,
	input logic [4:0] size_eff,
	output ssn_pkg::ssn_status_t status,
	output logic [31:0] out_value
);
	logic [31:0] work_q [ssn_pkg::NetSize];
	logic [4:0] count_q;
	logic [ssn_pkg::StepW-1:0] step_q;
	logic [4:0] emit_q;
	logic [9:0] pr;
	logic [4:0] ia;
	logic [4:0] ib;
	logic swap;

	assign pr = ssn_pkg::net_pair(step_q);
	assign ia = pr[9:5];
	assign ib = pr[4:0];
	assign swap = ssn_pkg::float_greater(work_q[ia], work_q[ib]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			step_q <= '0;
			emit_q <= '0;
		end else begin
			if (cmd.start) begin
				count_q <= '0;
				step_q <= '0;
				emit_q <= '0;
			end else if (cmd.store) begin
				count_q <= count_q + 5'd1;
			end
			if (cmd.sort_step) begin
				step_q <= step_q + ssn_pkg::StepW'(1);
			end
			if (cmd.emit_step) begin
				emit_q <= emit_q + 5'd1;
			end
		end
	end

	// payload array, no reset
	// a value stored past the current size would be padded anyway, so it is dropped
	always_ff @(posedge clk) begin
		if (cmd.store && count_q < 5'(MAX_ELEMENTS) && count_q < size_eff) begin
			work_q[count_q] <= in_value;
		end
		if (cmd.start) begin
			for (int i = 0; i < ssn_pkg::NetSize; i++) begin
				if (5'(i) >= size_eff) begin
					work_q[i] <= ssn_pkg::PosInf;
				end
			end
		end
		if (cmd.sort_step && swap) begin
			work_q[ia] <= work_q[ib];
			work_q[ib] <= work_q[ia];
		end
	end

	assign status.set_full = (count_q + 5'd1) >= size_eff;
	assign status.sort_done = step_q == ssn_pkg::StepW'(ssn_pkg::NetSteps - 1);
	assign status.emit_last = (emit_q + 5'd1) == size_eff;
	assign out_value = work_q[emit_q];
endmodule

@@ src/ssn_ctrl.sv @@
// controller state machine
module ssn_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input ssn_pkg::ssn_status_t status,
	output ssn_pkg::ssn_cmd_t cmd,
	output ssn_pkg::ssn_state_t state
);
	ssn_pkg::ssn_state_t state_q;
	ssn_pkg::ssn_state_t state_d;
	logic in_xfer;

	assign in_xfer = in_valid && state_q == ssn_pkg::ST_LOAD;
	assign state = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssn_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ssn_pkg::ST_LOAD: begin
				if (in_xfer && status.set_full) state_d = ssn_pkg::ST_SORT;
			end
			ssn_pkg::ST_SORT: begin
				if (status.sort_done) state_d = ssn_pkg::ST_EMIT;
			end
			ssn_pkg::ST_EMIT: begin
				if (out_ready && status.emit_last) state_d = ssn_pkg::ST_LOAD;
			end
			default: state_d = ssn_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd = '0;
		case (state_q)
			ssn_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				cmd.store = in_xfer;
				cmd.start = in_xfer && status.set_full;
			end
			ssn_pkg::ST_SORT: begin
				cmd.sort_step = 1'b1;
			end
			ssn_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				cmd.emit_step = out_ready;
			end
			default: ;
		endcase
	end
endmodule

@@ src/small_sorting_network.sv @@
// after the transfer that completes a set, the set is sorted, then one result per cycle while out_ready is high
// throughput: one input per cycle while loading; no new set is taken until the last result of the set is out
// the network runs one compare-exchange per cycle through a single float comparator
// reset clears the load count, the controller state and sets set_size to 9
// element storage is not reset; every emitted slot is written or padded first
module small_sorting_network #(
	parameter int MAX_ELEMENTS = 18
) (
	input logic clk,
	input logic arst_n,
	ssn_stream_if.sink in_ch,
	ssn_stream_if.source out_ch,
	input logic cfg_we,
	input logic [4:0] cfg_wdata
);
	`include "small_sorting_network_assert.svh"

	logic [4:0] set_size_q;
	logic [4:0] size_eff;
	ssn_pkg::ssn_cmd_t cmd;
	ssn_pkg::ssn_status_t status;
	ssn_pkg::ssn_state_t state;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q <= 5'd9;
		end else if (cfg_we) begin
			set_size_q <= cfg_wdata;
		end
	end

	// clamp the size into the supported range
	always_comb begin
		size_eff = set_size_q;
		if (size_eff < 5'd2) size_eff = 5'd2;
		if (size_eff > 5'(MAX_ELEMENTS)) size_eff = 5'(MAX_ELEMENTS);
	end

	ssn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.status(status), .cmd(cmd), .state(state)
	);

	ssn_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_value(in_ch.data), .size_eff(size_eff),
		.status(status), .out_value(out_ch.data)
	);

	// last marks the final transfer of the set
	assign out_ch.last = status.emit_last;

	`SSN_ASSERT(a_no_in_while_busy, (state != ssn_pkg::ST_LOAD) |-> !in_ch.ready, "input taken while busy")
	`SSN_ASSERT(a_sort_then_emit, (state == ssn_pkg::ST_SORT && status.sort_done) |=> out_ch.valid, "no emit after sort")
	`SSN_ASSERT(a_last_ends_set, (out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready, "set did not end")
endmodule

@@ dv/ssn_sort_checker.sv @@
// checker for the sorting network: predicts sorted sets and compares output transfers
module ssn_sort_checker (
	input logic clk,
	input logic arst_n,
	ssn_stream_if in_mon,
	ssn_stream_if out_mon,
	input logic cfg_we,
	input logic [4:0] cfg_wdata,
	output int fail_count,
	output int pending
);
	localparam int Slots = 18;
	localparam int Steps = 82;
	localparam logic [31:0] Infinity = 32'h7F80_0000;

	localparam int LoIdx [0:Steps-1] = '{
		0, 1, 2, 3, 4, 5, 6, 7, 0, 1, 2, 3, 10, 11, 8, 9, 0, 1, 6, 7,
		8, 9, 4, 5, 0, 1, 4, 5, 12, 13, 0, 4, 5, 8, 9, 12, 13, 2, 3,
		2, 3, 6, 7, 10, 11, 2, 3, 6, 7, 10, 11, 14, 15,
		2, 4, 6, 8, 10, 12, 14, 16, 1, 3, 5, 7, 1, 9, 3, 7, 11,
		1, 5, 9, 13, 1, 3, 5, 7, 9, 11, 13, 15};
	localparam int HiIdx [0:Steps-1] = '{
		16, 17, 10, 11, 12, 13, 14, 15, 8, 9, 6, 7, 14, 15, 16, 17, 4, 5, 10, 11,
		12, 13, 16, 17, 2, 3, 8, 9, 16, 17, 1, 6, 7, 10, 11, 14, 15, 16, 17,
		8, 9, 12, 13, 16, 17, 4, 5, 8, 9, 12, 13, 16, 17,
		3, 5, 7, 9, 11, 13, 15, 17, 16, 10, 12, 14, 8, 16, 6, 10, 14,
		4, 8, 12, 16, 2, 4, 6, 8, 10, 12, 14, 16};

	typedef struct {
		logic [31:0] sorted_value;
		logic        last;
	} sorted_item_t;

	logic [31:0] held_values [Slots];
	logic [4:0]  held_count;
	logic [4:0]  size_reg;
	sorted_item_t sorted_q [$];

	assign pending = sorted_q.size();

	// monotonic key, both zeros alike
	function automatic logic [31:0] rank_of(input logic [31:0] x);
		logic [31:0] y;
		y = (x[30:0] == 31'd0) ? 32'd0 : x;
		return y[31] ? ~y : {1'b1, y[30:0]};
	endfunction

	function automatic bit swaps(input logic [31:0] a, input logic [31:0] b);
		if (a[30:0] > 31'h7F80_0000 || b[30:0] > 31'h7F80_0000)
			return 1'b0;
		return rank_of(a) > rank_of(b);
	endfunction

	task automatic sort_and_queue(input int n);
		logic [31:0] work [Slots];
		logic [31:0] t;
		sorted_item_t it;
		for (int i = 0; i < Slots; i++)
			work[i] = (i < n) ? held_values[i] : Infinity;
		for (int k = 0; k < Steps; k++) begin
			if (swaps(work[LoIdx[k]], work[HiIdx[k]])) begin
				t = work[LoIdx[k]];
				work[LoIdx[k]] = work[HiIdx[k]];
				work[HiIdx[k]] = t;
			end
		end
		for (int i = 0; i < n; i++) begin
			it.sorted_value = work[i];
			it.last = (i == n - 1);
			sorted_q.push_back(it);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : predict
		int n;
		sorted_item_t want;
		if (!arst_n) begin
			held_count = '0;
			size_reg = 5'd9;
			fail_count = 0;
			sorted_q.delete();
		end else begin
			if (in_mon.valid && in_mon.ready) begin
				n = (size_reg < 2) ? 2 : (size_reg > Slots) ? Slots : size_reg;
				if (held_count < Slots)
					held_values[held_count] = in_mon.data;
				held_count = held_count + 5'd1;
				if (held_count >= n) begin
					sort_and_queue(n);
					held_count = '0;
				end
			end
			if (out_mon.valid && out_mon.ready) begin
				if (sorted_q.size() == 0) begin
					$error("unexpected output transfer: sorted_value %h last %b",
						out_mon.data, out_mon.last);
					fail_count++;
				end else begin
					want = sorted_q.pop_front();
					if (out_mon.data !== want.sorted_value) begin
						$error("sorted_value: expected %h, actual %h",
							want.sorted_value, out_mon.data);
						fail_count++;
					end
					if (out_mon.last !== want.last) begin
						$error("last: expected %b, actual %b", want.last, out_mon.last);
						fail_count++;
					end
				end
			end
			if (cfg_we)
				size_reg = cfg_wdata;
		end
	end
endmodule

@@ dv/tb_small_sorting_network.sv @@
// top of the sorting network testbench: stimulus, reset and verdict
module tb_small_sorting_network;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [4:0] cfg_wdata = 5'd0;
	int fail_count;
	int pending;
	int sent;

	ssn_stream_if #(.W(32)) in_ch ();
	ssn_stream_if #(.W(32)) out_ch ();

	// clock, 20 units per period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	small_sorting_network u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	ssn_sort_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_mon(in_ch),
		.out_mon(out_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.pending(pending)
	);

	// watchdog, far beyond the slowest correct run
	initial begin
		#20000000;
		$display("TB_ERROR");
		$finish;
	end

	// output side: random stall before each transfer, sometimes none
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ch.ready = 1'b0;
			repeat ($urandom_range(0, 10)) @(negedge clk);
			out_ch.ready = 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	// one input transfer with a random gap in front of it
	task automatic send_value(input logic [31:0] v);
		int gap;
		gap = $urandom_range(0, 10);
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data = v;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		in_ch.valid = 1'b0;
		sent++;
	endtask

	// wait for every predicted result, then let the network drain
	task automatic wait_idle();
		while (pending != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic write_size(input logic [4:0] s);
		cfg_we = 1'b1;
		cfg_wdata = s;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// mix of float extremes, zeros, infinities, rare nan and random patterns
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 15))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h7F80_0000;
			3: return 32'hFF80_0000;
			4: return {$urandom_range(0, 1) == 1, 31'h7F7F_FFFF};
			5: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom)};
			6: return ($urandom_range(0, 3) == 0) ? {1'b0, 8'hFF, 23'($urandom) | 23'd1}
				: 32'h3F80_0000;
			7: return {$urandom_range(0, 1) == 1, 8'd127, 20'd0, 3'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	initial begin : stimulus
		int n;
		int partial;
		sent = 0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		in_ch.last = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset size of nine, signed zeros, infinities, smallest denormals, largest finite values and one
		send_value(32'h0000_0000); send_value(32'h8000_0000);
		send_value(32'h7F80_0000); send_value(32'hFF80_0000);
		send_value(32'h0000_0001); send_value(32'h8000_0001);
		send_value(32'h7F7F_FFFF); send_value(32'hFF7F_FFFF);
		send_value(32'h3F80_0000);
		wait_idle();
		// signed zeros compare equal
		write_size(5'd2);
		send_value(32'h8000_0000); send_value(32'h0000_0000);
		wait_idle();
		// size below range behaves as two
		write_size(5'd0);
		send_value(32'h4000_0000); send_value(32'hC000_0000);
		wait_idle();
		// nan in a set
		write_size(5'd3);
		send_value(32'h7FC0_0000); send_value(32'hBF80_0000); send_value(32'h0000_0000);
		wait_idle();
		// size lowered with more values already loaded than the new size
		write_size(5'd5);
		repeat (4) send_value(pick_value());
		wait_idle();
		write_size(5'd3);
		send_value(pick_value());
		wait_idle();

		// random phases: mostly complete sets, sometimes a partial load before a resize
		while (sent < 310) begin
			case ($urandom_range(0, 9))
				0: n = $urandom_range(0, 1);
				1: n = $urandom_range(19, 31);
				2: n = 18;
				default: n = $urandom_range(2, 18);
			endcase
			write_size(5'(n));
			if (n < 2) n = 2;
			if (n > 18) n = 18;
			repeat ($urandom_range(1, 3)) begin
				repeat (n) send_value(pick_value());
			end
			if ($urandom_range(0, 4) == 0) begin
				partial = $urandom_range(1, n - 1);
				repeat (partial) send_value(pick_value());
			end
			wait_idle();
		end

		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

@@ files.f @@
+incdir+src
src/ssn_pkg.sv
src/ssn_stream_if.sv
src/ssn_datapath.sv
src/ssn_ctrl.sv
src/small_sorting_network.sv
dv/ssn_sort_checker.sv
dv/tb_small_sorting_network.sv
